/* hdl/geo_pkg.sv */
package geo_pkg;

    // Field widths of the point and of one hash character.
    localparam int LAT_BITS   = 32;
    localparam int LNG_BITS   = 33;
    localparam int COUNT_BITS = 4;
    localparam int CHAR_BITS  = 7;

    // Six extra fractional bits keep every halving of the box exact.
    localparam int FRAC_BITS = 6;

    // Signed width of the point-minus-low-bound offsets and of the half spans.
    localparam int DW = 40;

    localparam int DEF_MAX_CHARS = 12;

    // Half spans of the full box in units of 2^-30 degree.
    localparam logic [DW-1:0] LAT_HALF_SPAN = DW'(90)  << 30;
    localparam logic [DW-1:0] LNG_HALF_SPAN = DW'(180) << 30;

    // Geohash base32 alphabet: 0-9 then b-z without a, i, l, o.
    localparam logic [CHAR_BITS-1:0] CHR_ZERO = 7'h30;
    localparam logic [CHAR_BITS-1:0] CHR_B    = 7'h62;
    localparam logic [CHAR_BITS-1:0] CHR_Z    = 7'h7a;

    localparam logic [CHAR_BITS-1:0] ALPHABET [32] = '{
        CHR_ZERO, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
        7'h38, 7'h39, CHR_B, 7'h63, 7'h64, 7'h65, 7'h66, 7'h67,
        7'h68, 7'h6a, 7'h6b, 7'h6d, 7'h6e, 7'h70, 7'h71, 7'h72,
        7'h73, 7'h74, 7'h75, 7'h76, 7'h77, 7'h78, 7'h79, CHR_Z
    };

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;   // capture a new point, start from the full box
        logic step;   // produce one character into the output register
        logic last;   // the character being produced ends the hash
    } t_cmd;

endpackage

/* hdl/geo_in_if.sv */
interface geo_in_if;
    import geo_pkg::*;

    logic                         valid;
    logic                         ready;
    logic signed [LAT_BITS-1:0]   latitude;
    logic signed [LNG_BITS-1:0]   longitude;
    logic        [COUNT_BITS-1:0] char_count;

    modport source (output valid, output latitude, output longitude, output char_count,
                    input ready);
    modport sink   (input valid, input latitude, input longitude, input char_count,
                    output ready);
endinterface

/* hdl/geo_out_if.sv */
interface geo_out_if;
    import geo_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CHAR_BITS-1:0] hash_char;
    logic                 last_char;

    modport source (output valid, output hash_char, output last_char, input ready);
    modport sink   (input valid, input hash_char, input last_char, output ready);
endinterface

/* hdl/geo_ctrl.sv */
module geo_ctrl #(
    parameter int MAX_CHARS = geo_pkg::DEF_MAX_CHARS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic [geo_pkg::COUNT_BITS-1:0]  i_char_count,
    input  logic                            i_out_ready,
    output logic                            o_in_ready,
    output logic                            o_out_valid,
    output geo_pkg::t_cmd                   o_cmd
);
    import geo_pkg::*;

    localparam int CW = $clog2(MAX_CHARS + 1);

    t_state         r_state, n_state;
    logic [CW-1:0]  r_left, n_left;
    logic           r_out_valid, n_out_valid;
    logic [CW-1:0]  sat_count;
    logic           in_acc;
    logic           slot_free;

    // Counts above the limit saturate.
    assign sat_count = (i_char_count > COUNT_BITS'(MAX_CHARS)) ? CW'(MAX_CHARS)
                                                               : CW'(i_char_count);
    assign slot_free = !r_out_valid || i_out_ready;
    assign in_acc    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_left      <= n_left;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_left      = r_left;
        n_out_valid = r_out_valid && !i_out_ready;
        o_in_ready  = 1'b0;
        o_cmd       = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_left     = sat_count;
                    if (sat_count != '0) begin
                        n_state = ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                if (slot_free) begin
                    o_cmd.step  = 1'b1;
                    o_cmd.last  = (r_left == CW'(1));
                    n_out_valid = 1'b1;
                    n_left      = r_left - CW'(1);
                    if (r_left == CW'(1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

    a_start_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (sat_count != '0) |=> r_state == ST_RUN)
        else $error("nonzero count did not start a run");
    a_left_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_RUN |-> r_left != '0)
        else $error("run with no characters left");
    a_step_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.step |-> slot_free)
        else $error("step overwrote an untaken character");
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.step && o_cmd.last |=> r_state == ST_IDLE && r_out_valid)
        else $error("last character did not end the run");

endmodule

/* hdl/geo_dp.sv */
module geo_dp (
    input  logic                                i_clk,
    input  geo_pkg::t_cmd                       i_cmd,
    input  logic signed [geo_pkg::LAT_BITS-1:0] i_latitude,
    input  logic signed [geo_pkg::LNG_BITS-1:0] i_longitude,
    output logic [geo_pkg::CHAR_BITS-1:0]       o_hash_char,
    output logic                                o_last_char
);
    import geo_pkg::*;

    // Offsets of the point above the low bound of its axis, and current half spans.
    logic signed [DW-1:0] r_lat_d, r_lng_d, n_lat_d, n_lng_d;
    logic [DW-1:0]        r_lat_h, r_lng_h, n_lat_h, n_lng_h;
    logic                 r_odd;
    logic [CHAR_BITS-1:0] r_char;
    logic                 r_last;

    // Primary axis takes three bisections this character, secondary takes two.
    logic signed [DW-1:0] p_d0, p_d1, p_d2, p_d3;
    logic signed [DW-1:0] s_d0, s_d1, s_d2;
    logic [DW-1:0]        p_h, s_h;
    logic                 p_b0, p_b1, p_b2, s_b0, s_b1;
    logic [4:0]           code;
    logic signed [DW-1:0] lat_init, lng_init;

    function automatic logic [DW:0] bisect(input logic signed [DW-1:0] d,
                                           input logic [DW-1:0] h);
        logic up;
        up = d > $signed(h);
        return {up, up ? d - $signed(h) : d};
    endfunction

    assign lat_init = $signed({{(DW-LAT_BITS-FRAC_BITS){i_latitude[LAT_BITS-1]}},
                               i_latitude, {FRAC_BITS{1'b0}}}) + $signed(LAT_HALF_SPAN);
    assign lng_init = $signed({{(DW-LNG_BITS-FRAC_BITS){i_longitude[LNG_BITS-1]}},
                               i_longitude, {FRAC_BITS{1'b0}}}) + $signed(LNG_HALF_SPAN);

    // Even characters start on longitude, odd ones on latitude.
    assign p_d0 = r_odd ? r_lat_d : r_lng_d;
    assign p_h  = r_odd ? r_lat_h : r_lng_h;
    assign s_d0 = r_odd ? r_lng_d : r_lat_d;
    assign s_h  = r_odd ? r_lng_h : r_lat_h;

    assign {p_b0, p_d1} = bisect(p_d0, p_h);
    assign {s_b0, s_d1} = bisect(s_d0, s_h);
    assign {p_b1, p_d2} = bisect(p_d1, p_h >> 1);
    assign {s_b1, s_d2} = bisect(s_d1, s_h >> 1);
    assign {p_b2, p_d3} = bisect(p_d2, p_h >> 2);

    assign code = {p_b0, s_b0, p_b1, s_b1, p_b2};

    always_comb begin
        n_lat_d = r_lat_d;
        n_lng_d = r_lng_d;
        n_lat_h = r_lat_h;
        n_lng_h = r_lng_h;
        if (i_cmd.load) begin
            n_lat_d = lat_init;
            n_lng_d = lng_init;
            n_lat_h = LAT_HALF_SPAN;
            n_lng_h = LNG_HALF_SPAN;
        end else if (i_cmd.step) begin
            if (r_odd) begin
                n_lat_d = p_d3;
                n_lat_h = p_h >> 3;
                n_lng_d = s_d2;
                n_lng_h = s_h >> 2;
            end else begin
                n_lng_d = p_d3;
                n_lng_h = p_h >> 3;
                n_lat_d = s_d2;
                n_lat_h = s_h >> 2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_lat_d <= n_lat_d;
        r_lng_d <= n_lng_d;
        r_lat_h <= n_lat_h;
        r_lng_h <= n_lng_h;
        if (i_cmd.load) begin
            r_odd <= 1'b0;
        end else if (i_cmd.step) begin
            r_odd <= !r_odd;
        end
        if (i_cmd.step) begin
            r_char <= ALPHABET[code];
            r_last <= i_cmd.last;
        end
    end

    assign o_hash_char = r_char;
    assign o_last_char = r_last;

endmodule

/* hdl/geohash_encode_unit.sv */
// Channel   Modport  Beat                                      Direction
// i_pt      sink     latitude, longitude, char_count           in
// o_hash    source   hash_char, last_char                      out
//
// A point is loaded, then one character is produced per cycle unless
// o_hash stalls (five bisection compares: three chained on the primary
// axis, two on the secondary); a zero count produces no character.
// Reset (i_rst_n low, synchronous) empties the output register and idles
// the controller. A stalled o_hash holds the character and pauses the run;
// the next point is taken while the last character still waits.
module geohash_encode_unit #(
    parameter int MAX_CHARS = geo_pkg::DEF_MAX_CHARS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    geo_in_if.sink    i_pt,
    geo_out_if.source o_hash
);
    import geo_pkg::*;

    t_cmd cmd;   // controller to datapath
    logic in_ready;
    logic out_valid;

    // Controller: accepts points, counts characters, owns the output valid.
    geo_ctrl #(
        .MAX_CHARS (MAX_CHARS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_pt.valid),
        .i_char_count (i_pt.char_count),
        .i_out_ready  (o_hash.ready),
        .o_in_ready   (in_ready),
        .o_out_valid  (out_valid),
        .o_cmd        (cmd)
    );

    // Datapath: box offsets, half spans, one base32 digit per step.
    geo_dp u_dp (
        .i_clk       (i_clk),
        .i_cmd       (cmd),
        .i_latitude  (i_pt.latitude),
        .i_longitude (i_pt.longitude),
        .o_hash_char (o_hash.hash_char),
        .o_last_char (o_hash.last_char)
    );

    assign i_pt.ready   = in_ready;
    assign o_hash.valid = out_valid;

endmodule
